@@ rtl/bitmap_block_allocator_core_defines.svh @@
// Assertion macros for the allocator RTL.
`ifndef BITMAP_BLOCK_ALLOCATOR_CORE_DEFINES_SVH
`define BITMAP_BLOCK_ALLOCATOR_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define BBA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define BBA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/bba_pkg.sv @@
package bba_pkg;

  localparam int unsigned MAX_BLOCKS_DEF    = 4096;
  localparam int unsigned MAP_WORD_BITS_DEF = 32;

  localparam int unsigned TOTAL_W     = 13;
  localparam int unsigned BLK_NUM_W   = 12;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned IN_DATA_W   = 16;
  localparam int unsigned OUT_DATA_W  = 16;

  localparam logic [TOTAL_W-1:0] TOTAL_RESET = 13'd4096;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 2'd0,
    ST_NO_FREE      = 2'd1,
    ST_ALREADY_FREE = 2'd2,
    ST_OUT_OF_RANGE = 2'd3
  } status_t;

endpackage

@@ rtl/bitmap_block_allocator_core.sv @@
// Allocation: S_SCAN reads one map word per cycle while searching the word read before, and
// S_DONE registers the first free block or no-free. Free: S_FREE_RD reads the word, S_FREE_CHK
// clears the bit and S_DONE registers the status; an out-of-range free skips S_FREE_CHK.
// A new item is taken the cycle after its result is registered; an untaken result holds it off.
// Reset (rst_n low, synchronous) clears control state; then a clearing pass over
// all MAP_WORDS map words zeroes the bitmap before in_tready rises.
`include "bitmap_block_allocator_core_defines.svh"

module bitmap_block_allocator_core #(
  parameter int unsigned MAX_BLOCKS    = bba_pkg::MAX_BLOCKS_DEF,
  parameter int unsigned MAP_WORD_BITS = bba_pkg::MAP_WORD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [bba_pkg::TOTAL_W-1:0]     cfg_wr_data,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [bba_pkg::IN_DATA_W-1:0]   in_tdata,   // [11:0] block_number, rest zero
  input  logic                            in_tuser,   // [0] opcode
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [bba_pkg::OUT_DATA_W-1:0]  out_tdata,  // [11:0] allocated_block, rest zero
  output logic [bba_pkg::STATUS_W-1:0]    out_tuser   // [1:0] status
);
  import bba_pkg::*;

  localparam int unsigned WORD_SHIFT = $clog2(MAP_WORD_BITS);
  localparam int unsigned MAP_WORDS  = (MAX_BLOCKS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
  localparam int unsigned WA_W       = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int unsigned LIM_W      = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned BN_W       = WA_W + WORD_SHIFT;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_FREE_RD,
    S_FREE_CHK,
    S_DONE
  } state_t;

  state_t                 state_r, state_nxt;
  logic [TOTAL_W-1:0]     total_r;
  logic [WA_W-1:0]        clr_addr_r, clr_addr_nxt;
  logic [BLK_NUM_W-1:0]   blk_r, blk_nxt;
  logic [WA_W-1:0]        iss_word_r, iss_word_nxt;
  logic [LIM_W-1:0]       iss_rem_r, iss_rem_nxt;
  logic                   chk_vld_r, chk_vld_nxt;
  logic [WA_W-1:0]        chk_word_r, chk_word_nxt;
  logic [LIM_W-1:0]       chk_rem_r, chk_rem_nxt;
  logic [BLK_NUM_W-1:0]   res_blk_r, res_blk_nxt;
  status_t                res_st_r, res_st_nxt;
  logic                   out_vld_r, out_vld_nxt;
  logic [BLK_NUM_W-1:0]   out_blk_r, out_blk_nxt;
  status_t                out_st_r, out_st_nxt;

  logic [MAP_WORD_BITS-1:0] map_mem [MAP_WORDS];
  logic [MAP_WORD_BITS-1:0] rd_data_r;
  logic [WA_W-1:0]          rd_addr;
  logic                     mem_we;
  logic [WA_W-1:0]          mem_waddr;
  logic [MAP_WORD_BITS-1:0] mem_wdata;

  logic [LIM_W-1:0]         limit;
  logic                     out_free;
  logic                     scan_found;
  logic [WORD_SHIFT-1:0]    scan_idx;
  logic [MAP_WORD_BITS-1:0] scan_onehot;
  logic [WA_W-1:0]          free_word;
  logic [WORD_SHIFT-1:0]    free_bit;

  // Counts above capacity saturate at the capacity.
  assign limit = (32'(total_r) > MAX_BLOCKS) ? LIM_W'(MAX_BLOCKS) : LIM_W'(total_r);

  assign free_word = WA_W'(blk_r >> WORD_SHIFT);
  assign free_bit  = blk_r[WORD_SHIFT-1:0];
  assign out_free  = !out_vld_r || out_tready;

  bba_scan_unit #(
    .MAP_WORD_BITS (MAP_WORD_BITS),
    .LIM_W         (LIM_W)
  ) u_scan (
    .map_word   (rd_data_r),
    .rem_blocks (chk_rem_r),
    .found      (scan_found),
    .bit_idx    (scan_idx),
    .bit_onehot (scan_onehot)
  );

  always_ff @(posedge clk) begin
    if (mem_we) begin
      map_mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= map_mem[rd_addr];
  end

  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    blk_nxt      = blk_r;
    iss_word_nxt = iss_word_r;
    iss_rem_nxt  = iss_rem_r;
    chk_vld_nxt  = chk_vld_r;
    chk_word_nxt = chk_word_r;
    chk_rem_nxt  = chk_rem_r;
    res_blk_nxt  = res_blk_r;
    res_st_nxt   = res_st_r;
    out_vld_nxt  = out_vld_r;
    out_blk_nxt  = out_blk_r;
    out_st_nxt   = out_st_r;
    mem_we       = 1'b0;
    mem_waddr    = clr_addr_r;
    mem_wdata    = '0;
    rd_addr      = iss_word_r;

    if (out_vld_r && out_tready) begin
      out_vld_nxt = 1'b0;
    end

    case (state_r)
      S_CLEAR: begin
        mem_we       = 1'b1;
        clr_addr_nxt = clr_addr_r + WA_W'(1);
        if (clr_addr_r == WA_W'(MAP_WORDS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          blk_nxt      = in_tdata[BLK_NUM_W-1:0];
          iss_word_nxt = '0;
          iss_rem_nxt  = limit;
          chk_vld_nxt  = 1'b0;
          state_nxt    = (in_tuser == OP_FREE) ? S_FREE_RD : S_SCAN;
        end
      end
      S_SCAN: begin
        // One word is read while the word read in the previous cycle is searched.
        if (iss_rem_r != '0) begin
          chk_vld_nxt  = 1'b1;
          chk_word_nxt = iss_word_r;
          chk_rem_nxt  = iss_rem_r;
          iss_word_nxt = iss_word_r + WA_W'(1);
          iss_rem_nxt  = (32'(iss_rem_r) > MAP_WORD_BITS) ?
                         iss_rem_r - LIM_W'(MAP_WORD_BITS) : '0;
        end else begin
          chk_vld_nxt = 1'b0;
        end
        if (chk_vld_r && scan_found) begin
          mem_we      = 1'b1;
          mem_waddr   = chk_word_r;
          mem_wdata   = rd_data_r | scan_onehot;
          res_blk_nxt = BLK_NUM_W'(BN_W'({chk_word_r, scan_idx}));
          res_st_nxt  = ST_OK;
          state_nxt   = S_DONE;
        end else if (!chk_vld_r && iss_rem_r == '0) begin
          res_blk_nxt = '0;
          res_st_nxt  = ST_NO_FREE;
          state_nxt   = S_DONE;
        end
      end
      S_FREE_RD: begin
        rd_addr     = free_word;
        res_blk_nxt = '0;
        if (32'(blk_r) >= 32'(limit)) begin
          res_st_nxt = ST_OUT_OF_RANGE;
          state_nxt  = S_DONE;
        end else begin
          state_nxt = S_FREE_CHK;
        end
      end
      S_FREE_CHK: begin
        if (!rd_data_r[free_bit]) begin
          res_st_nxt = ST_ALREADY_FREE;
        end else begin
          mem_we     = 1'b1;
          mem_waddr  = free_word;
          mem_wdata  = rd_data_r & ~(MAP_WORD_BITS'(1) << free_bit);
          res_st_nxt = ST_OK;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          out_vld_nxt = 1'b1;
          out_blk_nxt = res_blk_r;
          out_st_nxt  = res_st_r;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      total_r    <= TOTAL_RESET;
      clr_addr_r <= '0;
      chk_vld_r  <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
      chk_vld_r  <= chk_vld_nxt;
      out_vld_r  <= out_vld_nxt;
      if (cfg_wr_en) begin
        total_r <= cfg_wr_data;
      end
    end
    blk_r      <= blk_nxt;
    iss_word_r <= iss_word_nxt;
    iss_rem_r  <= iss_rem_nxt;
    chk_word_r <= chk_word_nxt;
    chk_rem_r  <= chk_rem_nxt;
    res_blk_r  <= res_blk_nxt;
    res_st_r   <= res_st_nxt;
    out_blk_r  <= out_blk_nxt;
    out_st_r   <= out_st_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_vld_r;
  assign out_tdata  = OUT_DATA_W'(out_blk_r);
  assign out_tuser  = out_st_r;

  // A failed request never reports a block number.
  `BBA_ASSERT_NOW(a_err_blk_zero, out_vld_r && out_st_r != ST_OK, out_blk_r == '0,
    "error result carries a nonzero block number")
  // Allocation only ever sets a bit that was clear.
  `BBA_ASSERT_NOW(a_alloc_bit_free, state_r == S_SCAN && mem_we,
    (rd_data_r & scan_onehot) == '0, "allocation marks a block that is already used")
  // A word under search always has blocks left below the count.
  `BBA_ASSERT_NOW(a_chk_rem, state_r == S_SCAN && chk_vld_r, chk_rem_r != '0,
    "searched word lies beyond the block count")
  // The bitmap is not served before the clearing pass completes.
  `BBA_ASSERT_NEXT(a_clear_first, state_r == S_CLEAR && clr_addr_r != WA_W'(MAP_WORDS - 1),
    state_r == S_CLEAR, "clearing pass left early")

endmodule

@@ rtl/bba_scan_unit.sv @@
module bba_scan_unit #(
  parameter int unsigned MAP_WORD_BITS = bba_pkg::MAP_WORD_BITS_DEF,
  parameter int unsigned LIM_W         = 13
) (
  input  logic [MAP_WORD_BITS-1:0]         map_word,
  input  logic [LIM_W-1:0]                 rem_blocks,
  output logic                             found,
  output logic [$clog2(MAP_WORD_BITS)-1:0] bit_idx,
  output logic [MAP_WORD_BITS-1:0]         bit_onehot
);
  import bba_pkg::*;

  localparam int unsigned WORD_SHIFT = $clog2(MAP_WORD_BITS);

  logic [MAP_WORD_BITS-1:0] valid_mask;
  logic [MAP_WORD_BITS-1:0] free_bits;

  // Only bits that still fall below the block count take part in the search.
  always_comb begin
    for (int b = 0; b < MAP_WORD_BITS; b++) begin
      valid_mask[b] = (32'(b) < 32'(rem_blocks));
    end
  end

  assign free_bits  = ~map_word & valid_mask;
  // Two's complement trick isolates the lowest set bit.
  assign bit_onehot = free_bits & (~free_bits + MAP_WORD_BITS'(1));
  assign found      = |free_bits;

  always_comb begin
    bit_idx = '0;
    for (int b = 0; b < MAP_WORD_BITS; b++) begin
      if (bit_onehot[b]) begin
        bit_idx = bit_idx | WORD_SHIFT'(b);
      end
    end
  end

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 100ps

module tb;
  import bba_pkg::*;

  localparam int WORD_BITS   = MAP_WORD_BITS_DEF;
  localparam int MAP_DEPTH   = MAX_BLOCKS_DEF / MAP_WORD_BITS_DEF;
  localparam int IDLE_MAX    = 13;
  localparam int HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 800000;
  localparam int REPORT_MAX  = 10;

  typedef struct packed {
    logic [BLK_NUM_W-1:0] blk;
    status_t              st;
  } alloc_reply_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_wr_en;
  logic [TOTAL_W-1:0]    cfg_wr_data;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [STATUS_W-1:0]   out_tuser;

  // Shadow of the allocator: one in-use bit per block plus the block count.
  logic [WORD_BITS-1:0] used_words [MAP_DEPTH];
  logic [TOTAL_W-1:0]   block_count;

  alloc_reply_t pending_replies[$];

  int  cycle_count = 0;
  int  mismatches  = 0;
  int  alloc_reqs  = 0;
  int  free_reqs   = 0;
  int  status_seen [4];
  int  count_writes = 0;
  bit  tx_idle_on  = 1'b1;
  bit  rx_idle_on  = 1'b1;
  bit  rx_hold     = 1'b0;

  bitmap_block_allocator_core DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("Timeout after %0d cycles, %0d replies outstanding",
             cycle_count, pending_replies.size());
    $display("Simulation FAILED");
    $finish;
  end

  function automatic int live_count();
    return (block_count > MAX_BLOCKS_DEF) ? MAX_BLOCKS_DEF : int'(block_count);
  endfunction

  function automatic alloc_reply_t model_request(input logic op,
                                                 input logic [BLK_NUM_W-1:0] blk);
    alloc_reply_t r;
    int lim;
    int n;
    lim = live_count();
    r.blk = '0;
    if (op == OP_ALLOC) begin
      r.st = ST_NO_FREE;
      for (n = 0; n < lim; n++) begin
        if (!used_words[n / WORD_BITS][n % WORD_BITS]) begin
          used_words[n / WORD_BITS][n % WORD_BITS] = 1'b1;
          r.blk = n[BLK_NUM_W-1:0];
          r.st  = ST_OK;
          break;
        end
      end
    end else if (int'(blk) >= lim) begin
      r.st = ST_OUT_OF_RANGE;
    end else if (!used_words[blk / WORD_BITS][blk % WORD_BITS]) begin
      r.st = ST_ALREADY_FREE;
    end else begin
      used_words[blk / WORD_BITS][blk % WORD_BITS] = 1'b0;
      r.st = ST_OK;
    end
    return r;
  endfunction

  // Returns some block below the count that is currently in use, or -1.
  function automatic int pick_held_block();
    int lim;
    int start;
    int k;
    int n;
    lim = live_count();
    if (lim == 0) return -1;
    start = $urandom_range(0, lim - 1);
    for (k = 0; k < lim; k++) begin
      n = (start + k) % lim;
      if (used_words[n / WORD_BITS][n % WORD_BITS]) return n;
    end
    return -1;
  endfunction

  // Sends one request beat. Valid is left high after acceptance so that a
  // back-to-back request does not lower and raise it in the same step.
  task automatic send_request(input logic op, input logic [BLK_NUM_W-1:0] blk);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, IDLE_MAX) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {{(IN_DATA_W-BLK_NUM_W){1'b0}}, blk};
    do @(posedge clk); while (!in_tready);
    pending_replies.push_back(model_request(op, blk));
    if (op == OP_ALLOC) alloc_reqs++;
    else free_reqs++;
  endtask

  task automatic send_alloc();
    send_request(OP_ALLOC, BLK_NUM_W'($urandom));
  endtask

  task automatic send_free(input int blk);
    send_request(OP_FREE, blk[BLK_NUM_W-1:0]);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_block_count(input logic [TOTAL_W-1:0] value);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    block_count = value;
    count_writes++;
    cfg_wr_en   <= 1'b0;
    @(posedge clk);
  endtask

  // Result side: checks every accepted beat and draws a stall after each one.
  initial begin
    int stall;
    alloc_reply_t want;
    logic [OUT_DATA_W-1:0] want_data;
    stall = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (out_tvalid && out_tready) begin
        status_seen[out_tuser]++;
        if (pending_replies.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("[%0d] unexpected reply: block %0d status %0d",
                     cycle_count, out_tdata, out_tuser);
        end else begin
          want = pending_replies.pop_front();
          want_data = {{(OUT_DATA_W-BLK_NUM_W){1'b0}}, want.blk};
          if (out_tdata !== want_data || out_tuser !== want.st) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
              $display("[%0d] reply mismatch: block %0d/%0d status %0d/%0d (exp/act)",
                       cycle_count, want_data, out_tdata, want.st, out_tuser);
          end
        end
        stall = rx_idle_on ? $urandom_range(0, IDLE_MAX) : 0;
      end
      if (rx_hold) begin
        out_tready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
      @(posedge clk);
    end
  end

  task automatic test_default_count();
    // Count is 4096 out of reset.
    send_free(0);
    send_free(MAX_BLOCKS_DEF - 1);
    send_alloc();
    send_alloc();
    send_alloc();
    send_free(1);
    send_alloc();
    send_free(0);
    send_free(1);
    send_free(2);
  endtask

  task automatic test_count_extremes();
    set_block_count(TOTAL_W'(1));
    send_alloc();
    send_alloc();
    send_free(1);
    send_free(MAX_BLOCKS_DEF - 1);
    send_free(0);
    send_free(0);
    // A count of zero allows nothing at all.
    set_block_count(TOTAL_W'(0));
    send_alloc();
    send_free(0);
    // Counts above capacity behave as the full capacity.
    set_block_count({TOTAL_W{1'b1}});
    send_free(MAX_BLOCKS_DEF - 1);
    send_alloc();
    send_free(0);
    set_block_count(TOTAL_W'(MAX_BLOCKS_DEF - 1));
    send_free(MAX_BLOCKS_DEF - 1);
  endtask

  // One random request: mostly allocations and frees of held blocks, with
  // some frees of arbitrary or edge-of-range numbers mixed in.
  task automatic send_random_request(input int alloc_pct);
    int r;
    int held;
    int lim;
    r = $urandom_range(0, 99);
    lim = live_count();
    if (r < alloc_pct) begin
      send_alloc();
    end else if (r < 88) begin
      held = pick_held_block();
      if (held < 0) send_alloc();
      else send_free(held);
    end else if (r < 94) begin
      send_free($urandom_range(0, MAX_BLOCKS_DEF - 1));
    end else begin
      send_free((lim + $urandom_range(0, 2) + MAX_BLOCKS_DEF - 1) % MAX_BLOCKS_DEF);
    end
  endtask

  task automatic run_random_phase(input logic [TOTAL_W-1:0] count, input int alloc_pct,
                                  input int items, input bit tx_idle, input bit rx_idle);
    int k;
    set_block_count(count);
    tx_idle_on = tx_idle;
    rx_idle_on = rx_idle;
    for (k = 0; k < items; k++) send_random_request(alloc_pct);
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  task automatic test_random_mix();
    run_random_phase(TOTAL_W'($urandom_range(33, 96)), 55, 100, 1'b1, 1'b1);
    run_random_phase(TOTAL_W'(64), 60, 100, 1'b0, 1'b0);
    run_random_phase(TOTAL_W'(MAX_BLOCKS_DEF), 70, 120, 1'b1, 1'b1);
    run_random_phase({TOTAL_W{1'b1}}, 50, 80, 1'b1, 1'b0);
    run_random_phase(TOTAL_W'($urandom_range(1, 8)), 50, 80, 1'b0, 1'b1);
    run_random_phase(TOTAL_W'($urandom_range(97, 1000)), 65, 120, 1'b1, 1'b1);
  endtask

  task automatic test_output_backpressure();
    int k;
    wait_idle();
    tx_idle_on = 1'b0;
    rx_hold = 1'b1;
    fork
      begin
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold = 1'b0;
      end
    join_none
    for (k = 0; k < 40; k++) send_random_request(50);
    tx_idle_on = 1'b1;
  endtask

  initial begin
    int k;
    rst_n       <= 1'b0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= OP_ALLOC;
    out_tready  <= 1'b0;
    for (k = 0; k < MAP_DEPTH; k++) used_words[k] = '0;
    for (k = 0; k < 4; k++) status_seen[k] = 0;
    block_count = TOTAL_RESET;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_count();
    test_count_extremes();
    test_random_mix();
    test_output_backpressure();

    wait_idle();
    repeat (20) @(posedge clk);
    if (pending_replies.size() != 0) begin
      mismatches++;
      $display("%0d replies never arrived", pending_replies.size());
    end
    $display("Ran %0d allocations and %0d frees over %0d block-count settings (0 to 8191).",
             alloc_reqs, free_reqs, count_writes);
    $display("Replies ok/no-free/already-free/out-of-range: %0d/%0d/%0d/%0d; %0d mismatches.",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3], mismatches);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
